[hw/rtl/ddt_pkg.sv]
`default_nettype none
package ddt_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int MAX_REF       = 1024;

  localparam int IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int DIST_W    = 13;
  localparam int REF_W     = 10;
  localparam int BIN_W     = 13;
  localparam int TOTAL_W   = 48;
  localparam int HIST_AW   = $clog2(MAX_REF);
  localparam int KEY_W     = 256;

  // Command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [63:0] digest_word0;
    logic [63:0] digest_word1;
    logic [63:0] digest_word2;
    logic [63:0] digest_word3;
    logic [9:0]  bin_index;
  } in_t;

  typedef struct packed {
    logic               new_entry;
    logic [REF_W-1:0]   refs;
    logic [BIN_W-1:0]   bin_count;
    logic [TOTAL_W-1:0] chunks_added;
    logic [DIST_W-1:0]  distinct_entries;
    logic               table_full;
    logic               count_saturated;
  } out_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_HRD   = 6'b001000,
    S_HUPD  = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    H_READ = 3'b001,
    H_DEC  = 3'b010,
    H_INC  = 3'b100
  } hist_op_t;

endpackage
`default_nettype wire

[hw/rtl/ddt_ram.sv]
`default_nettype none
module ddt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/dedup_digest_refcount_table_unit.sv]
// Channel | Signals                       | Payload
// input   | in_valid, in_stall (driven)   | in_data  (ddt_pkg::in_t)
// output  | out_valid, out_stall (taken)  | out_data (ddt_pkg::out_t)
//
// An add is accepted, then scans the stored digests one per cycle until a hit
// or a miss. A new digest then takes one histogram read and update step, an
// increment takes two (decrement the old bin, increment the next), none when
// saturated or full, and a finish step follows. A bin read takes one histogram
// read and update step. After reset a clearing pass zeroes all 1024 histogram
// bins; no item is taken meanwhile. The block holds in its finish step while a
// stalled item still sits in the output register.
`default_nettype none
module dedup_digest_refcount_table_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ddt_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ddt_pkg::out_t      out_data
);
  import ddt_pkg::*;

  localparam logic [REF_W-1:0]  REF_TOP  = REF_W'(MAX_REF - 1);
  localparam logic [DIST_W-1:0] DIST_TOP = DIST_W'(TABLE_ENTRIES);
  localparam logic [TOTAL_W-1:0] TOTAL_TOP = {TOTAL_W{1'b1}};

  state_t               state;
  hist_op_t             hist_op;
  in_t                  item;
  out_t                 res;
  logic [HIST_AW-1:0]   clr_idx;
  logic [DIST_W-1:0]    scan_idx;
  logic                 pend;
  logic [IDX_W-1:0]     pend_idx;
  logic [HIST_AW-1:0]   hist_addr;
  logic [TOTAL_W-1:0]   chunk_total;
  logic [DIST_W-1:0]    distinct_count;

  logic [KEY_W-1:0]     key_q;
  logic [REF_W-1:0]     cnt_q;
  logic [BIN_W-1:0]     hist_q;
  logic                 key_we, cnt_we, hist_we;
  logic [IDX_W-1:0]     cnt_waddr;
  logic [REF_W-1:0]     cnt_wdata;
  logic [HIST_AW-1:0]   hist_waddr;
  logic [BIN_W-1:0]     hist_wdata;
  logic [KEY_W-1:0]     digest;
  logic                 issue, match, miss, out_free, accept;

  assign digest   = {item.digest_word0, item.digest_word1,
                     item.digest_word2, item.digest_word3};
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign issue    = (scan_idx < distinct_count);
  assign match    = pend && (key_q == digest);
  assign miss     = !issue && !pend;

  // Memory write controls
  always_comb begin
    key_we     = 1'b0;
    cnt_we     = 1'b0;
    cnt_waddr  = distinct_count[IDX_W-1:0];
    cnt_wdata  = REF_W'(1);
    hist_we    = 1'b0;
    hist_waddr = hist_addr;
    hist_wdata = hist_q;
    unique case (state)
      S_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_idx;
        hist_wdata = '0;
      end
      S_SCAN: begin
        if (match) begin
          cnt_we    = (cnt_q < REF_TOP);
          cnt_waddr = pend_idx;
          cnt_wdata = cnt_q + REF_W'(1);
        end else if (miss && distinct_count != DIST_TOP) begin
          key_we = 1'b1;
          cnt_we = 1'b1;
        end
      end
      S_HUPD: begin
        hist_we = (hist_op != H_READ);
        if (hist_op == H_DEC) begin
          hist_wdata = hist_q - BIN_W'(hist_q != '0);
        end else begin
          hist_wdata = hist_q + BIN_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  ddt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key (
    .clk   (clk),
    .we    (key_we),
    .waddr (distinct_count[IDX_W-1:0]),
    .wdata (digest),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (key_q)
  );

  ddt_ram #(.WIDTH(REF_W), .DEPTH(TABLE_ENTRIES)) u_cnt (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (cnt_q)
  );

  ddt_ram #(.WIDTH(BIN_W), .DEPTH(MAX_REF)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_addr),
    .rdata (hist_q)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_idx        <= '0;
      out_valid      <= 1'b0;
      chunk_total    <= '0;
      distinct_count <= '0;
      pend           <= 1'b0;
      scan_idx       <= '0;
      hist_op        <= H_READ;
    end else begin
      // present a finished item, drop it once taken
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + HIST_AW'(1);
          if (clr_idx == HIST_AW'(MAX_REF - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item     <= in_data;
            res      <= '0;
            scan_idx <= '0;
            pend     <= 1'b0;
            if (in_data.cmd == CMD_ADD) begin
              if (chunk_total != TOTAL_TOP) begin
                chunk_total <= chunk_total + TOTAL_W'(1);
              end
              state <= S_SCAN;
            end else if ({1'b0, in_data.bin_index} < 11'(MAX_REF)) begin
              hist_addr <= in_data.bin_index[HIST_AW-1:0];
              hist_op   <= H_READ;
              state     <= S_HRD;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          if (match) begin
            if (cnt_q >= REF_TOP) begin
              res.count_saturated <= 1'b1;
              res.refs            <= REF_TOP;
              state               <= S_FIN;
            end else begin
              res.refs  <= cnt_q + REF_W'(1);
              hist_addr <= cnt_q[HIST_AW-1:0];
              hist_op   <= H_DEC;
              state     <= S_HRD;
            end
          end else if (miss) begin
            if (distinct_count == DIST_TOP) begin
              res.table_full <= 1'b1;
              state          <= S_FIN;
            end else begin
              distinct_count <= distinct_count + DIST_W'(1);
              res.new_entry  <= 1'b1;
              res.refs       <= REF_W'(1);
              hist_addr      <= HIST_AW'(1);
              hist_op        <= H_INC;
              state          <= S_HRD;
            end
          end else begin
            // advance the scan one entry per cycle
            pend     <= issue;
            pend_idx <= scan_idx[IDX_W-1:0];
            if (issue) begin
              scan_idx <= scan_idx + DIST_W'(1);
            end
          end
        end
        S_HRD: begin
          state <= S_HUPD;
        end
        S_HUPD: begin
          unique case (hist_op)
            H_READ: begin
              res.bin_count <= hist_q;
              state         <= S_FIN;
            end
            H_DEC: begin
              hist_addr <= hist_addr + HIST_AW'(1);
              hist_op   <= H_INC;
              state     <= S_HRD;
            end
            default: begin
              state <= S_FIN;
            end
          endcase
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      out_data <= {res.new_entry, res.refs, res.bin_count, chunk_total,
                   distinct_count, res.table_full, res.count_saturated};
    end
  end

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && out_free |=> out_valid)
    else $error("finished item not presented");

  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    distinct_count <= DIST_TOP)
    else $error("distinct count exceeds table size");

  a_new_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.new_entry |->
      (out_data.refs == REF_W'(1)) && !out_data.table_full)
    else $error("inserted entry with bad count");

endmodule
`default_nettype wire
